>>> rtl/core/uww_pkg.sv
// shared types and constants for the greedy word wrapper
// no dependencies; used by uww_front, uww_back and the top level
`timescale 1ns / 1ps

package uww_pkg;

	localparam logic [20:0] CP_SPACE   = 21'd32;
	localparam logic [20:0] CP_NEWLINE = 21'd10;

	localparam logic [8:0] COLS_MAX = 9'd511;

	localparam logic [7:0] WRAP_COLUMNS_RESET = 8'd80;

	// config register file: one register, index taken from paddr[2]
	localparam int PADDR_W = 3;
	localparam logic REG_WRAP_COLUMNS = 1'b0;

	// classified character, as held in the front queue
	typedef struct packed {
		logic       eot;
		logic       is_space;
		logic       is_newline;
		logic [2:0] nbytes;
		logic [1:0] ncols;
	} item_t;

endpackage

>>> rtl/core/uww_front.sv
// front end: accepts characters, classifies them, holds them in a two-entry queue
// depends on uww_pkg
`timescale 1ns / 1ps

module uww_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [20:0]      codepoint,
	input  logic [2:0]       char_bytes,
	input  logic [1:0]       char_width,
	input  logic             end_of_text,
	output logic             item_valid,
	output uww_pkg::item_t   item,
	input  logic             item_take
);

	uww_pkg::item_t item_q [2];
	uww_pkg::item_t new_item;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	always_comb begin
		new_item.eot        = end_of_text;
		new_item.is_space   = (codepoint == uww_pkg::CP_SPACE);
		new_item.is_newline = (codepoint == uww_pkg::CP_NEWLINE);
		new_item.nbytes     = char_bytes;
		new_item.ncols      = char_width;
	end

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = item_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			item_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/uww_back.sv
// back end: line state update per character and a two-entry result queue
// depends on uww_pkg
`timescale 1ns / 1ps

module uww_back #(
	parameter int BUF_BYTES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [7:0]                          wrap_columns,
	input  logic                                item_valid,
	input  uww_pkg::item_t                      item,
	output logic                                item_take,
	input  logic                                pop,
	output logic                                empty,
	output logic [$clog2(BUF_BYTES+1)-1:0]      line_number,
	output logic [$clog2(BUF_BYTES+1)-1:0]      line_length,
	output logic [$clog2(BUF_BYTES+1)-1:0]      next_start,
	output logic                                final_line
);

	localparam int OFS_W = $clog2(BUF_BYTES + 1);
	localparam logic [OFS_W:0] BUF_LIM = (OFS_W + 1)'(BUF_BYTES);

	// line state
	logic [OFS_W-1:0] byte_offset_q;
	logic [OFS_W-1:0] line_bytes_q;
	logic [8:0]       line_cols_q;
	logic             space_seen_q;
	logic [OFS_W-1:0] space_offset_q;
	logic [OFS_W-1:0] space_line_bytes_q;
	logic [8:0]       space_line_cols_q;
	logic [OFS_W-1:0] line_index_q;

	// result queue
	logic [OFS_W-1:0] rq_number_q [2];
	logic [OFS_W-1:0] rq_length_q [2];
	logic [OFS_W-1:0] rq_next_q   [2];
	logic             rq_final_q  [2];
	logic             rq_wr_q;
	logic             rq_rd_q;
	logic [1:0]       rq_cnt_q;

	logic [OFS_W:0]   nxt_sum;
	logic [OFS_W-1:0] nxt;
	logic [OFS_W:0]   lb_sum;
	logic [OFS_W-1:0] lb;
	logic [9:0]       lc_sum;
	logic [8:0]       lc;
	logic             ss;
	logic [OFS_W-1:0] so;
	logic [OFS_W-1:0] slb;
	logic [8:0]       slc;
	logic [OFS_W:0]   so_sum;
	logic [OFS_W-1:0] so_inc;
	logic [OFS_W:0]   li_sum;
	logic [OFS_W-1:0] li_inc;
	logic             col_hit;
	logic             emit;
	logic [OFS_W-1:0] res_length;
	logic [OFS_W-1:0] res_next;
	logic             do_pop;

	always_comb begin
		nxt_sum = {1'b0, byte_offset_q} + (OFS_W + 1)'(item.nbytes);
		nxt     = (nxt_sum > BUF_LIM) ? BUF_LIM[OFS_W-1:0] : nxt_sum[OFS_W-1:0];
		lb_sum  = {1'b0, line_bytes_q} + (OFS_W + 1)'(item.nbytes);
		lb      = (lb_sum > BUF_LIM) ? BUF_LIM[OFS_W-1:0] : lb_sum[OFS_W-1:0];
		lc_sum  = {1'b0, line_cols_q} + 10'(item.ncols);
		lc      = (lc_sum > {1'b0, uww_pkg::COLS_MAX}) ? uww_pkg::COLS_MAX : lc_sum[8:0];

		// a space in this character updates the break point first
		ss  = space_seen_q || item.is_space;
		so  = item.is_space ? byte_offset_q : space_offset_q;
		slb = item.is_space ? lb : space_line_bytes_q;
		slc = item.is_space ? lc : space_line_cols_q;

		so_sum = {1'b0, so} + (OFS_W + 1)'(1);
		so_inc = (so_sum > BUF_LIM) ? BUF_LIM[OFS_W-1:0] : so_sum[OFS_W-1:0];
		li_sum = {1'b0, line_index_q} + (OFS_W + 1)'(1);
		li_inc = (li_sum > BUF_LIM) ? BUF_LIM[OFS_W-1:0] : li_sum[OFS_W-1:0];

		col_hit = (lc >= {1'b0, wrap_columns});

		// wrap back to the space only when the width is hit, a space is held
		// and the character is not a newline
		emit = item.eot || col_hit || item.is_newline;
		if (item.eot) begin
			res_length = line_bytes_q;
			res_next   = byte_offset_q;
		end else if (col_hit && ss && !item.is_newline) begin
			res_length = slb;
			res_next   = so_inc;
		end else begin
			res_length = lb;
			res_next   = nxt;
		end
	end

	assign item_take = item_valid && (rq_cnt_q != 2'd2);
	assign empty     = (rq_cnt_q == 2'd0);
	assign do_pop    = pop && !empty;

	assign line_number = rq_number_q[rq_rd_q];
	assign line_length = rq_length_q[rq_rd_q];
	assign next_start  = rq_next_q[rq_rd_q];
	assign final_line  = rq_final_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (item_take && emit) begin
			rq_number_q[rq_wr_q] <= line_index_q;
			rq_length_q[rq_wr_q] <= res_length;
			rq_next_q[rq_wr_q]   <= res_next;
			rq_final_q[rq_wr_q]  <= item.eot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q      <= '0;
			line_bytes_q       <= '0;
			line_cols_q        <= '0;
			space_seen_q       <= 1'b0;
			space_offset_q     <= '0;
			space_line_bytes_q <= '0;
			space_line_cols_q  <= '0;
			line_index_q       <= '0;
			rq_wr_q            <= 1'b0;
			rq_rd_q            <= 1'b0;
			rq_cnt_q           <= 2'd0;
		end else begin
			if (item_take) begin
				priority if (item.eot) begin
					byte_offset_q      <= '0;
					line_bytes_q       <= '0;
					line_cols_q        <= '0;
					space_seen_q       <= 1'b0;
					space_offset_q     <= '0;
					space_line_bytes_q <= '0;
					space_line_cols_q  <= '0;
					line_index_q       <= '0;
				end else if (emit) begin
					byte_offset_q      <= nxt;
					space_seen_q       <= 1'b0;
					space_offset_q     <= '0;
					space_line_bytes_q <= '0;
					space_line_cols_q  <= '0;
					line_index_q       <= li_inc;
					if (col_hit && ss && !item.is_newline) begin
						line_bytes_q <= (lb >= slb) ? lb - slb : '0;
						line_cols_q  <= (lc >= slc) ? lc - slc : '0;
					end else begin
						line_bytes_q <= '0;
						line_cols_q  <= '0;
					end
				end else begin
					byte_offset_q      <= nxt;
					line_bytes_q       <= lb;
					line_cols_q        <= lc;
					space_seen_q       <= ss;
					space_offset_q     <= so;
					space_line_bytes_q <= slb;
					space_line_cols_q  <= slc;
				end
			end
			if (item_take && emit) begin
				rq_wr_q <= !rq_wr_q;
			end
			if (do_pop) begin
				rq_rd_q <= !rq_rd_q;
			end
			unique case ({item_take && emit, do_pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + 2'd1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 2'd1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/utf8_greedy_word_wrap.sv
// top level of the greedy word wrapper: config register, front end, back end
// depends on uww_pkg, uww_front, uww_back
`timescale 1ns / 1ps

// greedy word wrapper for a utf-8 text display
//
// input channel: one decoded character per beat (codepoint, char_bytes,
// char_width) or an end-of-text marker; a beat is taken when push is high
// and full is low. result channel: one beat per completed line (line_number,
// line_length, next_start, final_line); the oldest result sits on the ports
// while empty is low and leaves when pop is high.
// a character that does not end a line gives no result.
//
// throughput: one character per clock while the result queue has room, set
// by the line state update in the back end. a line result is registered into
// the result queue as the back end takes the character that completed it.
// the front keeps a two-entry queue of classified characters, the back a
// two-entry result queue, so input keeps flowing while a result waits; when
// pop stays low both queues fill and full rises.
//
// config: wrap_columns at byte address 0 over the apb port, reset 80;
// write it only while no text is in flight.
// reset clears both queues and all line state; a new text starts at line 0,
// offset 0, and so does the text after every end-of-text marker.
module utf8_greedy_word_wrap #(
	parameter int BUF_BYTES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [uww_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// character input
	input  logic                                push,
	output logic                                full,
	input  logic [20:0]                         codepoint,
	input  logic [2:0]                          char_bytes,
	input  logic [1:0]                          char_width,
	input  logic                                end_of_text,
	// line results
	output logic                                empty,
	input  logic                                pop,
	output logic [$clog2(BUF_BYTES+1)-1:0]      line_number,
	output logic [$clog2(BUF_BYTES+1)-1:0]      line_length,
	output logic [$clog2(BUF_BYTES+1)-1:0]      next_start,
	output logic                                final_line
);

	logic [7:0]     wrap_columns_q;
	logic           cfg_wr;
	logic           item_valid;
	uww_pkg::item_t item;
	logic           item_take;

	// register index comes from paddr[2]; low address bits are ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == uww_pkg::REG_WRAP_COLUMNS) ? {24'd0, wrap_columns_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_columns_q <= uww_pkg::WRAP_COLUMNS_RESET;
		end else if (cfg_wr && (paddr[2] == uww_pkg::REG_WRAP_COLUMNS)) begin
			wrap_columns_q <= pwdata[7:0];
		end
	end

	// classify and queue characters
	uww_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.codepoint   (codepoint),
		.char_bytes  (char_bytes),
		.char_width  (char_width),
		.end_of_text (end_of_text),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take)
	);

	// line state and result queue
	uww_back #(
		.BUF_BYTES (BUF_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wrap_columns (wrap_columns_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take),
		.pop          (pop),
		.empty        (empty),
		.line_number  (line_number),
		.line_length  (line_length),
		.next_start   (next_start),
		.final_line   (final_line)
	);

endmodule

>>> rtl/core/uww_checker.sv
// port-level checks for the greedy word wrapper, bound to the top level
// depends on utf8_greedy_word_wrap
`timescale 1ns / 1ps

module uww_checker #(
	parameter int BUF_BYTES = 4096
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                pready,
	input logic                                full,
	input logic                                empty,
	input logic                                pop,
	input logic [$clog2(BUF_BYTES+1)-1:0]      line_number,
	input logic [$clog2(BUF_BYTES+1)-1:0]      line_length,
	input logic [$clog2(BUF_BYTES+1)-1:0]      next_start,
	input logic                                final_line
);

	localparam int OFS_W = $clog2(BUF_BYTES + 1);
	localparam logic [OFS_W-1:0] LIM = OFS_W'(BUF_BYTES);

	// config port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// right after reset the result queue is empty and full is low
	a_reset_clear: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("queues not clear after reset");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(line_number) && $stable(line_length)
			&& $stable(next_start) && $stable(final_line)))
		else $error("result changed while stalled");

	// offsets and counters saturate at the buffer size
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (line_length <= LIM && next_start <= LIM && line_number <= LIM))
		else $error("result beyond buffer size");

endmodule

bind utf8_greedy_word_wrap uww_checker #(
	.BUF_BYTES (BUF_BYTES)
) u_uww_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pready      (pready),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.line_number (line_number),
	.line_length (line_length),
	.next_start  (next_start),
	.final_line  (final_line)
);
